@@ src/rdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants for the reload down timer.
// ----------------------------------------------------------------------------
package rdt_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // register offsets
  localparam logic [2:0] OFF_RELOAD_LO = 3'd0;
  localparam logic [2:0] OFF_RELOAD_HI = 3'd1;
  localparam logic [2:0] OFF_COUNT_LO  = 3'd2;
  localparam logic [2:0] OFF_COUNT_HI  = 3'd3;
  localparam logic [2:0] OFF_CONTROL   = 3'd4;
  localparam logic [2:0] OFF_STATUS    = 3'd5;
  localparam logic [2:0] OFF_ACK       = 3'd6;

  // control byte bits
  localparam int CTRL_ENABLE_BIT   = 0;
  localparam int CTRL_AUTOLOAD_BIT = 1;
  localparam int CTRL_IRQ_EN_BIT   = 2;

  localparam int TIMER_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int CYCLES_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the incoming word
    logic do_write;  // apply the bus write
    logic do_step;   // one counted timer cycle
    logic out_load;  // capture the result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_e func;
    logic  enabled;
    logic  remain_zero;
  } status_t;

endpackage : rdt_pkg
`default_nettype wire

@@ src/reload_down_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reload_down_timer
// 16-bit down-counting interval timer with auto-reload behind byte registers.
//
// Input channel (in_valid_i / in_stall_o): one word is a bus read, a bus
// write or a tick (func_i), with reg_offset_i, write_data_i, tick_cycles_i.
// A word is taken when in_valid_i is high and in_stall_o is low. The block
// works on one word at a time; in_stall_o is low only while idle.
// Output channel (out_valid_o / out_stall_i): every input word yields one
// result word: read_data_o (read byte, zero otherwise) and irq_pending_o
// (overflow flag and interrupt enable), both after the word's effect.
// Sequence: an accepted word passes through RUN, where a write is applied
// or an enabled tick steps one timer cycle per clock, one step unit reused,
// until tick_cycles_i (at most 255) runs out or the timer stops on overflow,
// then FIN, which loads the result once the output register is free.
// A result held by out_stall_i does not block acceptance of the next word;
// only the delivery of the following result waits for the output register.
// Reset (rst_ni low, asynchronous) clears all timer registers, the overflow
// flag and the sequencer; no result is pending after reset.
// ----------------------------------------------------------------------------
module reload_down_timer
  import rdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          func_i,
  input  wire logic [2:0]          reg_offset_i,
  input  wire logic [BYTE_W-1:0]   write_data_i,
  input  wire logic [CYCLES_W-1:0] tick_cycles_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [BYTE_W-1:0]        read_data_o,
  output logic                     irq_pending_o
);

  cmd_t    cmd;
  status_t status;
  logic    out_valid_q, out_valid_d;
  logic    out_free;

  // output register can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  rdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .reg_offset_i  (reg_offset_i),
    .write_data_i  (write_data_i),
    .tick_cycles_i (tick_cycles_i),
    .status_o      (status),
    .read_data_o   (read_data_o),
    .irq_pending_o (irq_pending_o)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load)       out_valid_d = 1'b1;
    else if (!out_stall_i)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> out_free)
    else $error("result overwrote an undelivered word");

endmodule : reload_down_timer
`default_nettype wire

@@ src/rdt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdt_ctrl
// Sequencer: accept, execute (one counted cycle per clock on enabled ticks), deliver.
// ----------------------------------------------------------------------------
module rdt_ctrl
  import rdt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire logic    out_free_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic stepping;
  assign stepping = (status_i.func == FUNC_TICK) && status_i.enabled &&
                    !status_i.remain_zero;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (!stepping)  state_d = ST_FIN;
      ST_FIN:  if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.do_step  = stepping;
        cmd_o.do_write = (status_i.func == FUNC_WRITE);
      end
      ST_FIN: begin
        cmd_o.out_load = out_free_i;
      end
      default: ;
    endcase
  end

  a_step_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_step |-> state_q == ST_RUN)
    else $error("timer step outside run state");

  a_fin_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free_i) |=> state_q == ST_IDLE)
    else $error("finish did not return to idle");

  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_write |=> state_q == ST_FIN)
    else $error("bus write not followed by finish");

endmodule : rdt_ctrl
`default_nettype wire

@@ src/rdt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdt_datapath
// Timer registers, bus decode, counted-cycle step and result register.
// ----------------------------------------------------------------------------
module rdt_datapath
  import rdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  input  wire logic [1:0]          func_i,
  input  wire logic [2:0]          reg_offset_i,
  input  wire logic [BYTE_W-1:0]   write_data_i,
  input  wire logic [CYCLES_W-1:0] tick_cycles_i,
  output status_t                  status_o,
  output logic [BYTE_W-1:0]        read_data_o,
  output logic                     irq_pending_o
);

  // latched word
  func_e               func_q;
  logic [2:0]          off_q;
  logic [BYTE_W-1:0]   data_q;
  logic [CYCLES_W-1:0] remain_q;

  // architectural state
  logic [TIMER_W-1:0]  reload_q, reload_d;
  logic [TIMER_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0]   ctrl_q, ctrl_d;
  logic                ovf_q, ovf_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_e'(func_i);
      off_q    <= reg_offset_i;
      data_q   <= write_data_i;
      remain_q <= tick_cycles_i;
    end else if (cmd_i.do_step) begin
      remain_q <= remain_q - CYCLES_W'(1);
    end
  end

  always_comb begin
    reload_d = reload_q;
    count_d  = count_q;
    ctrl_d   = ctrl_q;
    ovf_d    = ovf_q;
    if (cmd_i.do_write) begin
      unique case (off_q)
        OFF_RELOAD_LO: reload_d[7:0]  = data_q;
        OFF_RELOAD_HI: reload_d[15:8] = data_q;
        OFF_CONTROL: begin
          ctrl_d = data_q;
          if (data_q[CTRL_ENABLE_BIT]) count_d = reload_q;
        end
        OFF_ACK: ovf_d = 1'b0;
        default: ;  // read-only or unmapped
      endcase
    end else if (cmd_i.do_step) begin
      if (count_q == '0) begin
        ovf_d = 1'b1;
        if (ctrl_q[CTRL_AUTOLOAD_BIT]) count_d = reload_q;
        else                           ctrl_d[CTRL_ENABLE_BIT] = 1'b0;
      end else begin
        count_d = count_q - TIMER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      count_q  <= '0;
      ctrl_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      reload_q <= reload_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      ovf_q    <= ovf_d;
    end
  end

  // reads have no side effects, so decode from the settled state
  logic [BYTE_W-1:0] rd_byte;
  always_comb begin
    rd_byte = '0;
    if (func_q == FUNC_READ) begin
      unique case (off_q)
        OFF_RELOAD_LO: rd_byte = reload_q[7:0];
        OFF_RELOAD_HI: rd_byte = reload_q[15:8];
        OFF_COUNT_LO:  rd_byte = count_q[7:0];
        OFF_COUNT_HI:  rd_byte = count_q[15:8];
        OFF_CONTROL:   rd_byte = ctrl_q;
        OFF_STATUS:    rd_byte = {{(BYTE_W-1){1'b0}}, ovf_q};
        default:       rd_byte = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_data_o   <= rd_byte;
      irq_pending_o <= ovf_q & ctrl_q[CTRL_IRQ_EN_BIT];
    end
  end

  assign status_o.func        = func_q;
  assign status_o.enabled     = ctrl_q[CTRL_ENABLE_BIT];
  assign status_o.remain_zero = (remain_q == '0);

  a_step_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_step |-> ctrl_q[CTRL_ENABLE_BIT] && remain_q != '0)
    else $error("step while disabled or exhausted");

  a_step_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_step |=> remain_q == $past(remain_q) - CYCLES_W'(1))
    else $error("remaining cycle count not decremented");

endmodule : rdt_datapath
`default_nettype wire
